FILE: design/gabc_pkg.sv
package gabc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_BLEND_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FG_COLOR     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_HEIGHT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEST_X       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DEST_Y       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DEST_WIDTH   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_DEST_HEIGHT  = 3'd7;

  localparam logic [7:0] ALPHA_MAX = 8'd255;

  typedef struct packed {
    logic [7:0]  glyph_column;
    logic [7:0]  glyph_row;
    logic [7:0]  source_alpha;
    logic [31:0] dest_pixel;
  } gabc_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] dest_index;
    logic [31:0] new_pixel;
  } gabc_out_t;

endpackage

FILE: design/glyph_alpha_blend_clip.sv
// Glyph coverage blend with clipping. One word is taken on every clock at
// which start_i is high; busy_o never asserts. Each word gives one result
// on result_o, marked by a one-cycle done_o strobe once the word has passed
// the input register and then the result register. The
// receiver cannot stall, so it must take a result on the cycle it appears.
// Positions that fall outside the glyph or the destination come back with
// write_enable low, index zero and the destination pixel unchanged.
// Configuration may be written only while no word is in flight.
module glyph_alpha_blend_clip (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  gabc_pkg::gabc_in_t            data_i,
  output logic                          done_o,
  output gabc_pkg::gabc_out_t           result_o,
  input  logic                          cfg_we_i,
  input  logic [gabc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gabc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import gabc_pkg::*;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  logic               blend_mode_q;
  logic [23:0]        fg_color_q;
  logic [8:0]         glyph_width_q;
  logic [8:0]         glyph_height_q;
  logic signed [13:0] dest_x_q;
  logic signed [13:0] dest_y_q;
  logic [12:0]        dest_width_q;
  logic [12:0]        dest_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q   <= 1'b1;
      fg_color_q     <= '0;
      glyph_width_q  <= '0;
      glyph_height_q <= '0;
      dest_x_q       <= '0;
      dest_y_q       <= '0;
      dest_width_q   <= '0;
      dest_height_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BLEND_MODE:   blend_mode_q   <= cfg_wdata_i[0];
        CFG_FG_COLOR:     fg_color_q     <= cfg_wdata_i[23:0];
        CFG_GLYPH_WIDTH:  glyph_width_q  <= cfg_wdata_i[8:0];
        CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_wdata_i[8:0];
        CFG_DEST_X:       dest_x_q       <= cfg_wdata_i[13:0];
        CFG_DEST_Y:       dest_y_q       <= cfg_wdata_i[13:0];
        CFG_DEST_WIDTH:   dest_width_q   <= cfg_wdata_i[12:0];
        CFG_DEST_HEIGHT:  dest_height_q  <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // input register
  logic     s1_vld_q;
  gabc_in_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_q <= data_i;
    end
  end

  // clip test, blend and index
  logic signed [14:0] px;
  logic signed [14:0] py;
  logic               inside_d;
  logic [7:0]         inv_a;
  logic [15:0]        mix_r, mix_g, mix_b;
  logic [25:0]        idx_full;

  assign px    = 15'(dest_x_q) + $signed({7'd0, s1_q.glyph_column});
  assign py    = 15'(dest_y_q) + $signed({7'd0, s1_q.glyph_row});
  assign inv_a = ALPHA_MAX - s1_q.source_alpha;
  assign inside_d = ({1'b0, s1_q.glyph_column} < glyph_width_q) &&
                    ({1'b0, s1_q.glyph_row} < glyph_height_q) &&
                    !px[14] && !py[14] &&
                    (px[13:0] < {1'b0, dest_width_q}) &&
                    (py[13:0] < {1'b0, dest_height_q});

  assign mix_r = {8'd0, fg_color_q[23:16]} * {8'd0, s1_q.source_alpha} +
                 {8'd0, s1_q.dest_pixel[23:16]} * {8'd0, inv_a};
  assign mix_g = {8'd0, fg_color_q[15:8]} * {8'd0, s1_q.source_alpha} +
                 {8'd0, s1_q.dest_pixel[15:8]} * {8'd0, inv_a};
  assign mix_b = {8'd0, fg_color_q[7:0]} * {8'd0, s1_q.source_alpha} +
                 {8'd0, s1_q.dest_pixel[7:0]} * {8'd0, inv_a};

  assign idx_full = {13'd0, py[12:0]} * {13'd0, dest_width_q} + {13'd0, px[12:0]};

  gabc_out_t res_d;

  always_comb begin
    res_d = '0;
    if (!inside_d) begin
      res_d.new_pixel = s1_q.dest_pixel;
    end else begin
      res_d.write_enable = 1'b1;
      res_d.dest_index   = idx_full[23:0];
      if (blend_mode_q) begin
        res_d.new_pixel = {s1_q.dest_pixel[31:24], div255(mix_r), div255(mix_g),
                           div255(mix_b)};
      end else begin
        res_d.new_pixel = {s1_q.source_alpha, fg_color_q};
      end
    end
  end

  logic      done_q;
  gabc_out_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      result_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start_i, 2) && $past(rst_ni, 2) |-> done_o)
    else $error("result strobe missing two clocks after start");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s1_vld_q))
    else $error("result strobe without a word in flight");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.write_enable |-> result_o.dest_index == '0)
    else $error("clipped result carries a nonzero index");

  a_clip_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !inside_d |=> result_o.new_pixel == $past(s1_q.dest_pixel))
    else $error("clipped result altered the destination pixel");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gabc_pkg::*;

  localparam int unsigned OPAQUE      = 255;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RAND_PHASES = 13;
  localparam int          PHASE_WORDS = 72;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  gabc_in_t            data_i;
  logic                done_o;
  gabc_out_t           result_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  glyph_alpha_blend_clip dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .data_i      (data_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the block's registers
  logic              mode_blend;
  logic [23:0]       fg_rgb;
  logic [8:0]        glyph_w, glyph_h;
  logic signed [13:0] org_x, org_y;
  logic [12:0]       dst_w, dst_h;

  gabc_in_t  pending_pixels[$];
  gabc_out_t expected_px[$];

  logic took_q;
  bit   idle_on;
  int   gap_left = 0;
  int   errors, words_sent, drawn_count, clipped_count, settings_count, cycle_count;

  function automatic gabc_out_t blend_pixel(gabc_in_t w);
    gabc_out_t   r;
    int          px, py, idx;
    int unsigned a, fgc, dc, mixed;
    r.write_enable = 1'b0;
    r.dest_index   = '0;
    r.new_pixel    = w.dest_pixel;
    px = int'(org_x) + int'(w.glyph_column);
    py = int'(org_y) + int'(w.glyph_row);
    if (int'(w.glyph_column) < int'(glyph_w) && int'(w.glyph_row) < int'(glyph_h) &&
        px >= 0 && py >= 0 && px < int'(dst_w) && py < int'(dst_h)) begin
      idx = py * int'(dst_w) + px;
      r.write_enable = 1'b1;
      r.dest_index   = idx[23:0];
      a = 32'(w.source_alpha);
      if (mode_blend) begin
        r.new_pixel[31:24] = w.dest_pixel[31:24];
        for (int k = 0; k < 3; k++) begin
          fgc = 32'(fg_rgb[8*k +: 8]);
          dc  = 32'(w.dest_pixel[8*k +: 8]);
          mixed = (fgc * a + dc * (OPAQUE - a)) / OPAQUE;
          r.new_pixel[8*k +: 8] = mixed[7:0];
        end
      end else begin
        r.new_pixel = {w.source_alpha, fg_rgb};
      end
    end
    return r;
  endfunction

  // bits above the register width carry junk; the block must ignore them
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int val, int width);
    logic [23:0] mask, v;
    mask = 24'((1 << width) - 1);
    v = 24'($urandom);
    v = (v & ~mask) | (24'(val) & mask);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      CFG_BLEND_MODE:   mode_blend = v[0];
      CFG_FG_COLOR:     fg_rgb     = v;
      CFG_GLYPH_WIDTH:  glyph_w    = v[8:0];
      CFG_GLYPH_HEIGHT: glyph_h    = v[8:0];
      CFG_DEST_X:       org_x      = v[13:0];
      CFG_DEST_Y:       org_y      = v[13:0];
      CFG_DEST_WIDTH:   dst_w      = v[12:0];
      CFG_DEST_HEIGHT:  dst_h      = v[12:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(bit mode, int fg, int gw, int gh, int dx, int dy, int dw,
                              int dh);
    write_reg(CFG_BLEND_MODE, mode, 1);
    write_reg(CFG_FG_COLOR, fg, 24);
    write_reg(CFG_GLYPH_WIDTH, gw, 9);
    write_reg(CFG_GLYPH_HEIGHT, gh, 9);
    write_reg(CFG_DEST_X, dx, 14);
    write_reg(CFG_DEST_Y, dy, 14);
    write_reg(CFG_DEST_WIDTH, dw, 13);
    write_reg(CFG_DEST_HEIGHT, dh, 13);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  task automatic push_pixel(int col, int row, int alpha, logic [31:0] pix);
    gabc_in_t w;
    w.glyph_column = 8'(col);
    w.glyph_row    = 8'(row);
    w.source_alpha = 8'(alpha);
    w.dest_pixel   = pix;
    pending_pixels.insert(pending_pixels.size(), w);
  endtask

  // coordinates mostly near the glyph box so clipping edges are hit often
  task automatic queue_pixels(int n);
    int cmax, rmax, col, row, alpha;
    cmax = int'(glyph_w) + 3;
    rmax = int'(glyph_h) + 3;
    if (cmax > 255) cmax = 255;
    if (rmax > 255) rmax = 255;
    for (int i = 0; i < n; i++) begin
      col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cmax);
      row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, rmax);
      case ($urandom_range(0, 3))
        0:       alpha = 0;
        1:       alpha = 255;
        default: alpha = $urandom_range(0, 255);
      endcase
      push_pixel(col, row, alpha, $urandom);
    end
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || start_i || expected_px.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic int pick_glyph_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 256;
      2:       return $urandom_range(257, 511);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic int pick_dest_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 4096;
      2:       return 8191;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic int pick_origin();
    case ($urandom_range(0, 9))
      0:       return -8192;
      1:       return 8191;
      2:       return $urandom_range(0, 16383) - 8192;
      default: return $urandom_range(0, 80) - 40;
    endcase
  endfunction

  // driver: start held until taken, then a random gap while idle_on is set
  always @(negedge clk_i) begin : drive
    logic go;
    if (rst_ni) begin
      go = start_i;
      if (start_i && took_q) begin
        go = 1'b0;
        gap_left = idle_on ? $urandom_range(0, 8) : 0;
        words_sent++;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pixels.size() != 0) begin
          go = 1'b1;
          data_i <= pending_pixels[0];
          pending_pixels.delete(0);
        end
      end
      start_i <= go;
    end
  end

  // monitor: predict on accept, check on done
  always @(posedge clk_i) begin : observe
    gabc_out_t want;
    if (!rst_ni) begin
      took_q <= 1'b0;
    end else begin
      took_q <= start_i && !busy_o;
      if (start_i && !busy_o)
        expected_px.insert(expected_px.size(), blend_pixel(data_i));
      if (done_o) begin
        if (expected_px.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: %h", $time, result_o);
        end else begin
          want = expected_px[0];
          expected_px.delete(0);
          if (result_o.write_enable) drawn_count++;
          else clipped_count++;
          if (result_o.write_enable !== want.write_enable) begin
            errors++;
            $display("%0t: write_enable expected %0b got %0b", $time, want.write_enable,
                     result_o.write_enable);
          end
          if (result_o.dest_index !== want.dest_index) begin
            errors++;
            $display("%0t: dest_index expected %h got %h", $time, want.dest_index,
                     result_o.dest_index);
          end
          if (result_o.new_pixel !== want.new_pixel) begin
            errors++;
            $display("%0t: new_pixel expected %h got %h", $time, want.new_pixel,
                     result_o.new_pixel);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_px.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    start_i     = 1'b0;
    data_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    mode_blend  = 1'b1;
    fg_rgb      = '0;
    glyph_w     = '0;
    glyph_h     = '0;
    org_x       = '0;
    org_y       = '0;
    dst_w       = '0;
    dst_h       = '0;
    idle_on     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry is empty: everything clipped
    push_pixel(0, 0, 255, 32'hFFFF_FFFF);
    push_pixel(255, 255, 0, 32'h0000_0000);
    wait_idle();

    set_geometry(1, 'hFF8000, 16, 16, 2, 3, 64, 64);
    push_pixel(0, 0, 0, 32'hFFFF_FFFF);
    push_pixel(0, 0, 255, 32'h0000_0000);
    push_pixel(15, 15, 128, 32'h80FF_00AA);
    push_pixel(16, 0, 200, 32'h1122_3344);
    push_pixel(0, 16, 200, 32'h5566_7788);
    push_pixel(255, 255, 99, 32'hDEAD_BEEF);
    push_pixel(7, 7, 1, 32'h1234_5678);
    wait_idle();

    idle_on = 1'b1;
    set_geometry(0, 'hFFFFFF, 16, 16, 2, 3, 64, 64);
    push_pixel(0, 0, 255, 32'hA5A5_A5A5);
    push_pixel(5, 9, 0, 32'h5A5A_5A5A);
    push_pixel(15, 15, 77, 32'hFFFF_FFFF);
    wait_idle();

    // glyph wholly off the left and top edges
    set_geometry(1, 'h00FF00, 256, 256, -8192, -8192, 4096, 4096);
    push_pixel(255, 0, 255, 32'hFFFF_FFFF);
    push_pixel(0, 255, 255, 32'h0000_0000);
    wait_idle();

    set_geometry(1, 'h0000FF, 256, 256, -3, -2, 4096, 4096);
    push_pixel(2, 1, 255, 32'h0102_0304);
    push_pixel(3, 2, 128, 32'hF0E0_D0C0);
    push_pixel(255, 255, 64, 32'h7F7F_7F7F);
    wait_idle();

    // oversized registers, index wraps
    set_geometry(0, 'h123456, 511, 511, 8000, 8000, 8191, 8191);
    push_pixel(190, 190, 255, 32'h0000_0000);
    push_pixel(191, 0, 10, 32'hCAFE_F00D);
    push_pixel(190, 191, 20, 32'hBADC_0FFE);
    wait_idle();

    set_geometry(1, 'hABCDEF, 8, 8, 0, 0, 0, 10);
    push_pixel(0, 0, 255, 32'h1357_9BDF);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p % 3) != 0;
      set_geometry($urandom_range(0, 1), $urandom, pick_glyph_size(), pick_glyph_size(),
                   pick_origin(), pick_origin(), pick_dest_size(), pick_dest_size());
      queue_pixels(PHASE_WORDS);
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("Run covered %0d pixels over %0d register settings", words_sent,
             settings_count);
    $display("%0d pixels drawn, %0d clipped", drawn_count, clipped_count);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/gabc_pkg.sv
design/glyph_alpha_blend_clip.sv
tb/tb.sv
